FILE: src/fdts_pkg.sv
// ============================================================================
// fdts_pkg: shared types and constants for the framed decimal text sender
// Character codes, the conversion constants and the frame record that moves
// from the converter to the byte emitter.
// ============================================================================
`default_nettype none

package fdts_pkg;

    // Frame characters
    localparam logic [7:0] OPEN_MARK  = 8'h3C;   // '<'
    localparam logic [7:0] CLOSE_MARK = 8'h3E;   // '>'
    localparam logic [7:0] MINUS_MARK = 8'h2D;   // '-'
    localparam logic [7:0] DIGIT_ZERO = 8'h30;   // '0'

    // Text is cut to this many characters (sign included)
    localparam int MAX_TEXT_CHARS = 4;

    // A 16-bit magnitude (at most 32768) has up to five decimal digits
    localparam int SPEED_W    = 16;
    localparam int NUM_DIGITS = 5;
    localparam int DIV_STAGES = NUM_DIGITS - 1;
    localparam int ND_W       = 3;

    // x / 10 == (x * RECIP_10) >> RECIP_SHIFT for every 16-bit x
    localparam logic [15:0] RECIP_10    = 16'd52429;
    localparam int          RECIP_SHIFT = 19;
    localparam int          PROD_W      = 32;
    localparam int          QUOT_W      = PROD_W - RECIP_SHIFT;

    // Widths for the frame record and the byte cursor
    localparam int KEEP_W = $clog2(MAX_TEXT_CHARS + 1);
    localparam int POS_W  = $clog2(MAX_TEXT_CHARS + 2);
    localparam int IDX_W  = (MAX_TEXT_CHARS > 1) ? $clog2(MAX_TEXT_CHARS) : 1;

    typedef logic [7:0] char_t;

    typedef struct packed {
        logic [MAX_TEXT_CHARS-1:0][7:0] text;   // text characters, first at index 0
        logic [KEEP_W-1:0]              keep;   // number of text characters sent
    } frame_t;

endpackage

`default_nettype wire

FILE: src/fdts_in_if.sv
// ============================================================================
// fdts_in_if: value channel
// Carries one signed 16-bit value per beat with a valid/ready handshake.
// ============================================================================
`default_nettype none

interface fdts_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [fdts_pkg::SPEED_W-1:0]   speed;

    modport source (output valid, output speed, input ready);
    modport sink   (input valid, input speed, output ready);
endinterface

`default_nettype wire

FILE: src/fdts_out_if.sv
// ============================================================================
// fdts_out_if: byte channel
// Carries one frame byte per beat; last_byte marks the closing byte.
// ============================================================================
`default_nettype none

interface fdts_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       last_byte;

    modport source (output valid, output tx_byte, output last_byte, input ready);
    modport sink   (input valid, input tx_byte, input last_byte, output ready);
endinterface

`default_nettype wire

FILE: src/fdts_front.sv
// ============================================================================
// fdts_front: value to decimal text converter
// Pipelined: take the magnitude and digit count, peel one decimal digit per
// stage by reciprocal multiply, then lay the text out for the emitter.
// ============================================================================
`default_nettype none

module fdts_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    fdts_in_if.sink              sample,
    output fdts_pkg::frame_t     frame,
    output logic                 frame_valid,
    input  wire logic            frame_ready
);

    localparam int LAST = fdts_pkg::DIV_STAGES;

    logic                               vld_reg [0:LAST];
    logic                               neg_reg [0:LAST];
    logic [fdts_pkg::ND_W-1:0]          nd_reg  [0:LAST];
    logic [fdts_pkg::SPEED_W-1:0]       x_reg   [0:LAST];
    logic [fdts_pkg::DIV_STAGES-1:0][3:0] dig_reg [0:LAST];

    logic                               adv;
    logic                               in_neg;
    logic [fdts_pkg::SPEED_W-1:0]       in_mag;
    logic [fdts_pkg::ND_W-1:0]          in_nd;
    logic [fdts_pkg::PROD_W-1:0]        prod [0:LAST-1];
    logic [fdts_pkg::SPEED_W-1:0]       quot [0:LAST-1];
    logic [3:0]                         rem  [0:LAST-1];
    logic [3:0]                         digs [0:fdts_pkg::NUM_DIGITS-1];
    logic [fdts_pkg::ND_W:0]            nt;

    // Advance the whole pipe unless the final stage is blocked
    assign adv          = !vld_reg[LAST] || frame_ready;
    assign sample.ready = adv;
    assign frame_valid  = vld_reg[LAST];

    // Sign, magnitude and digit count of the incoming value
    always_comb
    begin
        in_neg = sample.speed[fdts_pkg::SPEED_W-1];
        in_mag = in_neg ? fdts_pkg::SPEED_W'(-sample.speed) : fdts_pkg::SPEED_W'(sample.speed);
        if (in_mag >= 16'd10000)
            in_nd = 3'd5;
        else if (in_mag >= 16'd1000)
            in_nd = 3'd4;
        else if (in_mag >= 16'd100)
            in_nd = 3'd3;
        else if (in_mag >= 16'd10)
            in_nd = 3'd2;
        else
            in_nd = 3'd1;
    end

    // One divide by ten per stage
    always_comb
    begin
        for (int s = 0; s < LAST; s++)
        begin
            prod[s] = fdts_pkg::PROD_W'(x_reg[s]) * fdts_pkg::PROD_W'(fdts_pkg::RECIP_10);
            quot[s] = fdts_pkg::SPEED_W'(prod[s][fdts_pkg::PROD_W-1:fdts_pkg::RECIP_SHIFT]);
            rem[s]  = 4'(x_reg[s] - ((quot[s] << 3) + (quot[s] << 1)));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= LAST; s++)
                vld_reg[s] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= sample.valid;
            for (int s = 1; s <= LAST; s++)
                vld_reg[s] <= vld_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            neg_reg[0] <= in_neg;
            nd_reg[0]  <= in_nd;
            x_reg[0]   <= in_mag;
            dig_reg[0] <= '0;
            for (int s = 1; s <= LAST; s++)
            begin
                neg_reg[s] <= neg_reg[s-1];
                nd_reg[s]  <= nd_reg[s-1];
                x_reg[s]   <= quot[s-1];
                for (int d = 0; d < fdts_pkg::DIV_STAGES; d++)
                    dig_reg[s][d] <= (d == s - 1) ? rem[s-1] : dig_reg[s-1][d];
            end
        end
    end

    // Lay out the text: optional minus, then digits most significant first
    always_comb
    begin
        int pos;
        for (int d = 0; d < fdts_pkg::DIV_STAGES; d++)
            digs[d] = dig_reg[LAST][d];
        digs[fdts_pkg::NUM_DIGITS-1] = x_reg[LAST][3:0];

        nt = (fdts_pkg::ND_W+1)'(nd_reg[LAST]) + (fdts_pkg::ND_W+1)'(neg_reg[LAST]);
        if (nt > (fdts_pkg::ND_W+1)'(fdts_pkg::MAX_TEXT_CHARS))
            frame.keep = fdts_pkg::KEEP_W'(fdts_pkg::MAX_TEXT_CHARS);
        else
            frame.keep = fdts_pkg::KEEP_W'(nt);

        for (int j = 0; j < fdts_pkg::MAX_TEXT_CHARS; j++)
        begin
            pos = neg_reg[LAST] ? int'(nd_reg[LAST]) - j : int'(nd_reg[LAST]) - 1 - j;
            if (neg_reg[LAST] && j == 0)
                frame.text[j] = fdts_pkg::MINUS_MARK;
            else if (pos >= 0 && pos < fdts_pkg::NUM_DIGITS)
                frame.text[j] = fdts_pkg::DIGIT_ZERO + {4'b0, digs[3'(pos)]};
            else
                frame.text[j] = fdts_pkg::DIGIT_ZERO;
        end
    end

endmodule

`default_nettype wire

FILE: src/fdts_queue.sv
// ============================================================================
// fdts_queue: two-entry frame queue
// Decouple the converter from the byte emitter so each can stall alone.
// ============================================================================
`default_nettype none

module fdts_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire fdts_pkg::frame_t  push_frame,
    input  wire logic              push_valid,
    output logic                   push_ready,
    output fdts_pkg::frame_t       pop_frame,
    output logic                   pop_valid,
    input  wire logic              pop_ready
);

    fdts_pkg::frame_t mem_reg [0:1];
    logic             wptr_reg;
    logic             rptr_reg;
    logic [1:0]       count_reg;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_frame  = mem_reg[rptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wptr_reg <= !wptr_reg;
            if (pop)
                rptr_reg <= !rptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= push_frame;
    end

endmodule

`default_nettype wire

FILE: src/fdts_back.sv
// ============================================================================
// fdts_back: frame byte emitter
// Walk the head frame one byte per beat into a registered output stage.
// ============================================================================
`default_nettype none

module fdts_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire fdts_pkg::frame_t  frame,
    input  wire logic              frame_valid,
    output logic                   frame_pop,
    fdts_out_if.source             tx
);

    logic [fdts_pkg::POS_W-1:0] cursor_reg;
    logic [fdts_pkg::POS_W-1:0] cursor_next;
    logic                       out_valid_reg;
    logic [7:0]                 out_byte_reg;
    logic                       out_last_reg;
    logic                       load;
    logic [fdts_pkg::POS_W-1:0] text_pos;
    logic [7:0]                 byte_sel;
    logic                       last_sel;

    assign tx.valid     = out_valid_reg;
    assign tx.tx_byte   = out_byte_reg;
    assign tx.last_byte = out_last_reg;

    // Load a new byte whenever a frame is waiting and the output stage is empty or draining
    assign load      = frame_valid && (!out_valid_reg || tx.ready);
    assign frame_pop = load && last_sel;
    assign text_pos  = cursor_reg - fdts_pkg::POS_W'(1);

    always_comb
    begin
        last_sel = 1'b0;
        if (cursor_reg == '0)
            byte_sel = fdts_pkg::OPEN_MARK;
        else if (cursor_reg <= fdts_pkg::POS_W'(frame.keep))
            byte_sel = frame.text[text_pos[fdts_pkg::IDX_W-1:0]];
        else
        begin
            byte_sel = fdts_pkg::CLOSE_MARK;
            last_sel = 1'b1;
        end
        cursor_next = last_sel ? '0 : cursor_reg + fdts_pkg::POS_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                cursor_reg <= cursor_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (tx.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= byte_sel;
            out_last_reg <= last_sel;
        end
    end

endmodule

`default_nettype wire

FILE: src/framed_decimal_text_sender.sv
// ============================================================================
// framed_decimal_text_sender: signed value to framed ASCII decimal bytes
// Top level: converter pipeline, frame queue and byte emitter.
// ============================================================================
// Each signed 16-bit value taken on the sample channel comes out on the tx
// channel as one frame of bytes: '<', the decimal text of the value ('-' first
// when negative) cut to its first four characters, then '>' with last_byte
// set. A frame is 3 to 6 beats, one byte per cycle while tx.ready is high, so
// a stream of values runs at one value per frame length; the byte-wide output
// register sets that limit. The converter is a five stage pipeline (sign and
// magnitude first, then one divide by ten in each of the four stages after
// it, by reciprocal multiply) that takes a value every cycle while it has
// room; with the queue empty, the first byte of a frame passes through those
// stages, the queue entry and the output register. A two-frame queue lets
// the converter keep taking values while the emitter is still sending or tx
// is stalled. No state carries from one value to the next.
// ============================================================================
`default_nettype none

module framed_decimal_text_sender (
    input  wire logic   clk,
    input  wire logic   rst_n,
    fdts_in_if.sink     sample,
    fdts_out_if.source  tx
);

    fdts_pkg::frame_t conv_frame;
    logic             conv_valid;
    logic             conv_ready;
    fdts_pkg::frame_t head_frame;
    logic             head_valid;
    logic             head_pop;

    // Convert: magnitude, digits and text layout
    fdts_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample      (sample),
        .frame       (conv_frame),
        .frame_valid (conv_valid),
        .frame_ready (conv_ready)
    );

    // Buffer finished frames between converter and emitter
    fdts_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_frame (conv_frame),
        .push_valid (conv_valid),
        .push_ready (conv_ready),
        .pop_frame  (head_frame),
        .pop_valid  (head_valid),
        .pop_ready  (head_pop)
    );

    // Emit the head frame one beat at a time
    fdts_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame       (head_frame),
        .frame_valid (head_valid),
        .frame_pop   (head_pop),
        .tx          (tx)
    );

    // The marked beat is always the closing character
    assert property (@(posedge clk) disable iff (!rst_n)
        tx.valid && tx.last_byte |-> tx.tx_byte == fdts_pkg::CLOSE_MARK)
        else $error("last beat is not the closing mark");

    // After a frame ends, the next beat opens a new frame
    assert property (@(posedge clk) disable iff (!rst_n)
        tx.valid && tx.ready && tx.last_byte |=>
            !tx.valid || tx.tx_byte == fdts_pkg::OPEN_MARK)
        else $error("frame does not start with the opening mark");

    // The emitter releases a queue entry only when one is present
    assert property (@(posedge clk) disable iff (!rst_n)
        head_pop |-> head_valid)
        else $error("frame popped from an empty queue");

endmodule

`default_nettype wire
